// File: rtl/core/hlst_pkg.sv
package hlst_pkg;

    // Field widths fixed by the item formats.
    localparam int PORT_W     = 16;
    localparam int ADDR_W     = 32;
    localparam int TIME_W     = 32;
    localparam int RTT_W      = 16;
    localparam int COUNT_W    = 16;
    localparam int HOP_W      = 6;

    // Running-mean divider: a 32-bit sum over a 17-bit divisor, 16 quotient bits.
    localparam int DIVIDEND_W = 32;
    localparam int DIVISOR_W  = 17;
    localparam int QUOT_W     = 16;
    localparam int STEP_W     = 4;

    // Defaults.
    localparam int TABLE_DEPTH_DEF             = 64;
    localparam logic [PORT_W-1:0] BASE_PORT_RESET = 16'd33440;
    localparam logic [RTT_W-1:0] RTT_LIMIT       = 16'hFFFF;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT   = 16'hFFFF;

    // One received probe reply.
    typedef struct packed {
        logic [PORT_W-1:0] quoted_dest_port;
        logic [ADDR_W-1:0] source_address;
        logic [TIME_W-1:0] sent_time_ms;
        logic [TIME_W-1:0] now_time_ms;
    } t_probe;

    // One result item.
    typedef struct packed {
        logic [HOP_W-1:0]   hop_index;
        logic               index_ok;
        logic [ADDR_W-1:0]  hop_address;
        logic [RTT_W-1:0]   last_rtt;
        logic [RTT_W-1:0]   min_rtt;
        logic [RTT_W-1:0]   max_rtt;
        logic [RTT_W-1:0]   mean_rtt;
        logic [COUNT_W-1:0] reply_count;
    } t_result;

    // One stored table entry.
    typedef struct packed {
        logic [ADDR_W-1:0]  address;
        logic [COUNT_W-1:0] count;
        logic [RTT_W-1:0]   last;
        logic [RTT_W-1:0]   min;
        logic [RTT_W-1:0]   max;
        logic [RTT_W-1:0]   mean;
    } t_entry;

    // Divider status toward the controller.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_START,
        ST_DIV,
        ST_WB
    } t_state;

endpackage

// File: rtl/core/hlst_ram.sv
module hlst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/hlst_div.sv
module hlst_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [hlst_pkg::DIVIDEND_W-1:0]     i_dividend,
    input  logic [hlst_pkg::DIVISOR_W-1:0]      i_divisor,
    output hlst_pkg::t_div_stat                 o_stat,
    output logic [hlst_pkg::QUOT_W-1:0]         o_quotient
);

    localparam int QW = hlst_pkg::QUOT_W;
    localparam int DW = hlst_pkg::DIVISOR_W;
    localparam logic [hlst_pkg::STEP_W-1:0] LAST_STEP = hlst_pkg::STEP_W'(QW - 1);

    logic [DW-1:0]                 r_rem;
    logic [QW-1:0]                 r_low;
    logic [DW-1:0]                 r_div;
    logic [hlst_pkg::STEP_W-1:0]   r_step;
    logic                          r_busy;
    logic                          r_done;

    logic [DW:0]   w_trial;
    logic [DW:0]   w_diff;
    logic          w_ge;
    logic [DW-1:0] n_rem;

    // One restoring step: shift in the next dividend bit and try the subtract.
    always_comb begin
        w_trial = {r_rem, r_low[QW-1]};
        w_diff  = w_trial - {1'b0, r_div};
        w_ge    = (w_trial >= {1'b0, r_div});
        n_rem   = w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
    end

    // The upper half of the dividend is already below the divisor, so it
    // seeds the remainder; the lower half shifts out while quotient bits shift in.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_rem  <= {1'b0, i_dividend[hlst_pkg::DIVIDEND_W-1:QW]};
                r_low  <= i_dividend[QW-1:0];
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_low  <= {r_low[QW-2:0], w_ge};
                r_step <= r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_low;

endmodule

// File: rtl/core/hop_latency_stats_table.sv
// Path: an item in range goes through the table read, the statistics update, the
// bit-serial mean divider and write back before its result is registered.
// An item outside the table goes straight to write back.
// Throughput: one item at a time; the next item is taken only once write back has finished
// and the controller is idle again, and write back waits while an earlier result is not yet taken.
// Reset: synchronous, active low; all entries read as zero and base_port is 33440.
module hop_latency_stats_table #(
    parameter int TABLE_DEPTH = hlst_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  hlst_pkg::t_probe              i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output hlst_pkg::t_result             o_out_item,
    input  logic                          i_cfg_we,
    input  logic [hlst_pkg::PORT_W-1:0]   i_cfg_data
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int ENTRY_W = $bits(hlst_pkg::t_entry);
    localparam logic [hlst_pkg::PORT_W:0] DEPTH_LIM = (hlst_pkg::PORT_W + 1)'(TABLE_DEPTH);

    hlst_pkg::t_state r_state;
    hlst_pkg::t_state n_state;

    logic [hlst_pkg::PORT_W-1:0]   r_base;
    logic [TABLE_DEPTH-1:0]        r_valid;

    // Captured item.
    logic [hlst_pkg::HOP_W-1:0]    r_hop;
    logic [IDX_W-1:0]              r_ptr;
    logic                          r_ok;
    logic                          r_hit;
    logic [hlst_pkg::ADDR_W-1:0]   r_src;
    logic [hlst_pkg::TIME_W-1:0]   r_sent;
    logic [hlst_pkg::TIME_W-1:0]   r_now;

    // Update in progress.
    hlst_pkg::t_entry              r_new;
    logic [hlst_pkg::RTT_W-1:0]    r_rtt;
    logic [hlst_pkg::DIVIDEND_W-1:0] r_prod;
    logic [hlst_pkg::DIVISOR_W-1:0]  r_divisor;

    // Output register.
    logic                          r_out_valid;
    hlst_pkg::t_result             r_out_item;

    logic [hlst_pkg::PORT_W-1:0]   w_diff16;
    logic                          w_in_range;
    logic                          w_accept;
    logic                          w_ram_re;
    logic                          w_div_start;
    logic                          w_wb_fire;
    logic [ENTRY_W-1:0]            w_rd_data;
    hlst_pkg::t_entry              w_entry;
    hlst_pkg::t_entry              w_wr_entry;
    logic [hlst_pkg::TIME_W-1:0]   w_elapsed;
    logic [hlst_pkg::RTT_W-1:0]    w_rtt;
    logic [hlst_pkg::DIVIDEND_W-1:0] w_prod;
    hlst_pkg::t_div_stat           w_div;
    logic [hlst_pkg::QUOT_W-1:0]   w_quot;

    // Hop index of the offered item, modulo the port width.
    assign w_diff16   = i_in_item.quoted_dest_port - r_base;
    assign w_in_range = ({1'b0, w_diff16} < DEPTH_LIM);
    assign w_accept   = i_in_valid && o_in_ready;

    // Entries never written since reset read as zero.
    assign w_entry = r_hit ? hlst_pkg::t_entry'(w_rd_data) : '0;

    // Elapsed time: negative gives zero, anything past 16 bits saturates.
    always_comb begin
        w_elapsed = r_now - r_sent;
        if (w_elapsed[hlst_pkg::TIME_W-1]) begin
            w_rtt = '0;
        end else if (|w_elapsed[hlst_pkg::TIME_W-2:hlst_pkg::RTT_W]) begin
            w_rtt = hlst_pkg::RTT_LIMIT;
        end else begin
            w_rtt = w_elapsed[hlst_pkg::RTT_W-1:0];
        end
    end

    assign w_prod = 32'(w_entry.count) * 32'(w_entry.mean);

    // Written entry takes the mean from the divider.
    always_comb begin
        w_wr_entry      = r_new;
        w_wr_entry.mean = w_quot;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hlst_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_in_range ? hlst_pkg::ST_CALC : hlst_pkg::ST_WB;
                end
            end
            hlst_pkg::ST_CALC:  n_state = hlst_pkg::ST_START;
            hlst_pkg::ST_START: n_state = hlst_pkg::ST_DIV;
            hlst_pkg::ST_DIV: begin
                if (w_div.done) begin
                    n_state = hlst_pkg::ST_WB;
                end
            end
            hlst_pkg::ST_WB: begin
                if (w_wb_fire) begin
                    n_state = hlst_pkg::ST_IDLE;
                end
            end
            default: n_state = hlst_pkg::ST_IDLE;
        endcase
    end

    // Control outputs of the state machine.
    always_comb begin
        o_in_ready  = 1'b0;
        w_ram_re    = 1'b0;
        w_div_start = 1'b0;
        w_wb_fire   = 1'b0;
        unique case (r_state)
            hlst_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                w_ram_re   = i_in_valid;
            end
            hlst_pkg::ST_START: w_div_start = 1'b1;
            hlst_pkg::ST_WB:    w_wb_fire = !r_out_valid || i_out_ready;
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // State, configuration and valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hlst_pkg::ST_IDLE;
            r_base  <= hlst_pkg::BASE_PORT_RESET;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_base <= i_cfg_data;
            end
            if (w_wb_fire && r_ok) begin
                r_valid[r_ptr] <= 1'b1;
            end
        end
    end

    // Item capture and statistics update.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hop  <= w_diff16[hlst_pkg::HOP_W-1:0];
            r_ptr  <= w_diff16[IDX_W-1:0];
            r_ok   <= w_in_range;
            r_hit  <= r_valid[w_diff16[IDX_W-1:0]];
            r_src  <= i_in_item.source_address;
            r_sent <= i_in_item.sent_time_ms;
            r_now  <= i_in_item.now_time_ms;
        end
        if (r_state == hlst_pkg::ST_CALC) begin
            r_rtt         <= w_rtt;
            r_prod        <= w_prod;
            r_divisor     <= {1'b0, w_entry.count} + 1'b1;
            r_new.address <= r_src;
            r_new.last    <= w_rtt;
            r_new.mean    <= w_entry.mean;
            r_new.count   <= (w_entry.count == hlst_pkg::COUNT_LIMIT) ?
                             w_entry.count : w_entry.count + 1'b1;
            r_new.min     <= (w_entry.min > w_rtt || w_entry.min == '0) ?
                             w_rtt : w_entry.min;
            r_new.max     <= (w_entry.max < w_rtt || w_entry.max == '0) ?
                             w_rtt : w_entry.max;
        end
    end

    // Output register: holds a result while the next item is worked on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_wb_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wb_fire) begin
            r_out_item.hop_index <= r_hop;
            r_out_item.index_ok  <= r_ok;
            if (r_ok) begin
                r_out_item.hop_address <= w_wr_entry.address;
                r_out_item.last_rtt    <= w_wr_entry.last;
                r_out_item.min_rtt     <= w_wr_entry.min;
                r_out_item.max_rtt     <= w_wr_entry.max;
                r_out_item.mean_rtt    <= w_wr_entry.mean;
                r_out_item.reply_count <= w_wr_entry.count;
            end else begin
                r_out_item.hop_address <= '0;
                r_out_item.last_rtt    <= '0;
                r_out_item.min_rtt     <= '0;
                r_out_item.max_rtt     <= '0;
                r_out_item.mean_rtt    <= '0;
                r_out_item.reply_count <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Entry store.
    hlst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_wb_fire && r_ok),
        .i_waddr (r_ptr),
        .i_wdata (ENTRY_W'(w_wr_entry)),
        .i_re    (w_ram_re),
        .i_raddr (w_diff16[IDX_W-1:0]),
        .o_rdata (w_rd_data)
    );

    // Bit-serial divider for the running mean.
    hlst_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_prod + 32'(r_rtt)),
        .i_divisor  (r_divisor),
        .o_stat     (w_div),
        .o_quotient (w_quot)
    );

    // The divider is quiet whenever a new item can be taken.
    a_idle_div_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !w_div.busy)
        else $error("divider busy while accepting items");

    // The divider finishes only while the controller waits for it.
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> (r_state == hlst_pkg::ST_DIV))
        else $error("divider done outside the divide state");

    // An updated entry always has a nonzero count; an ignored item has none.
    a_count_matches_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.index_ok == (o_out_item.reply_count != '0)))
        else $error("reply count disagrees with index_ok");

    // A result is loaded only from the write-back state, which then returns to idle.
    a_wb_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wb_fire |=> (r_state == hlst_pkg::ST_IDLE) && o_out_valid)
        else $error("write-back did not complete");

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int DEPTH       = hlst_pkg::TABLE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 6000000;
    localparam int DRAIN_WAIT  = 40;
    localparam int HOP_BURST   = 100;
    localparam int PHASE_ITEMS = 280;

    // Tracks the hop table, predicts each result and checks what comes back.
    class hop_table_tracker;
        logic [hlst_pkg::ADDR_W-1:0]  hop_addr [DEPTH];
        logic [hlst_pkg::COUNT_W-1:0] hop_count [DEPTH];
        logic [hlst_pkg::RTT_W-1:0]   hop_last [DEPTH];
        logic [hlst_pkg::RTT_W-1:0]   hop_min [DEPTH];
        logic [hlst_pkg::RTT_W-1:0]   hop_max [DEPTH];
        logic [hlst_pkg::RTT_W-1:0]   hop_mean [DEPTH];
        logic [hlst_pkg::PORT_W-1:0]  base_port;
        hlst_pkg::t_result            pending_results [$];
        int                           mismatches;

        function new();
            for (int i = 0; i < DEPTH; i++) begin
                hop_addr[i]  = '0;
                hop_count[i] = '0;
                hop_last[i]  = '0;
                hop_min[i]   = '0;
                hop_max[i]   = '0;
                hop_mean[i]  = '0;
            end
            base_port  = hlst_pkg::BASE_PORT_RESET;
            mismatches = 0;
        endfunction

        function void set_base_port(logic [hlst_pkg::PORT_W-1:0] value);
            base_port = value;
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        // Applies one reply to the table copy and queues the result it should produce.
        function void record_probe(hlst_pkg::t_probe p);
            logic [hlst_pkg::PORT_W-1:0] offset;
            logic [hlst_pkg::TIME_W-1:0] diff;
            logic [hlst_pkg::RTT_W-1:0]  rtt;
            logic [63:0]                 total;
            hlst_pkg::t_result           r;
            int                          i;
            r = '0;
            offset = p.quoted_dest_port - base_port;
            r.hop_index = offset[hlst_pkg::HOP_W-1:0];
            if (offset < DEPTH) begin
                i = int'(offset);
                diff = p.now_time_ms - p.sent_time_ms;
                // A negative difference reads as zero; long waits clamp at the limit.
                if (diff[hlst_pkg::TIME_W-1]) begin
                    rtt = '0;
                end else if (diff > 32'(hlst_pkg::RTT_LIMIT)) begin
                    rtt = hlst_pkg::RTT_LIMIT;
                end else begin
                    rtt = diff[hlst_pkg::RTT_W-1:0];
                end
                total = 64'(hop_count[i]) * 64'(hop_mean[i]) + 64'(rtt);
                hop_addr[i] = p.source_address;
                hop_last[i] = rtt;
                // A stored zero means the bound has not been set yet.
                if (hop_max[i] < rtt || hop_max[i] == '0) begin
                    hop_max[i] = rtt;
                end
                if (hop_min[i] > rtt || hop_min[i] == '0) begin
                    hop_min[i] = rtt;
                end
                hop_mean[i] = 16'(total / (64'(hop_count[i]) + 64'd1));
                if (hop_count[i] != hlst_pkg::COUNT_LIMIT) begin
                    hop_count[i] = hop_count[i] + 1'b1;
                end
                r.index_ok    = 1'b1;
                r.hop_address = hop_addr[i];
                r.last_rtt    = hop_last[i];
                r.min_rtt     = hop_min[i];
                r.max_rtt     = hop_max[i];
                r.mean_rtt    = hop_mean[i];
                r.reply_count = hop_count[i];
            end
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        // Compares one result item with the oldest prediction.
        function void check_result(hlst_pkg::t_result got);
            hlst_pkg::t_result want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result item, actual %0h", $time, got);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("hop_index", want.hop_index, got.hop_index);
            compare_field("index_ok", want.index_ok, got.index_ok);
            compare_field("hop_address", want.hop_address, got.hop_address);
            compare_field("last_rtt", want.last_rtt, got.last_rtt);
            compare_field("min_rtt", want.min_rtt, got.min_rtt);
            compare_field("max_rtt", want.max_rtt, got.max_rtt);
            compare_field("mean_rtt", want.mean_rtt, got.mean_rtt);
            compare_field("reply_count", want.reply_count, got.reply_count);
        endfunction
    endclass

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        in_valid;
    logic                        o_in_ready;
    hlst_pkg::t_probe            in_item;
    logic                        o_out_valid;
    logic                        out_ready;
    hlst_pkg::t_result           o_out_item;
    logic                        cfg_we;
    logic [hlst_pkg::PORT_W-1:0] cfg_data;

    hop_table_tracker tracker;
    bit               no_idle;
    int               cycle_count;

    hop_latency_stats_table #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    // Known values on every input from time zero.
    initial begin
        i_clk    = 1'b0;
        i_rst_n  = 1'b0;
        in_valid = 1'b0;
        in_item  = '0;
        out_ready = 1'b0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        no_idle  = 1'b0;
        cycle_count = 0;
        tracker  = new();
    end

    always #2 i_clk = ~i_clk;

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result items are checked at the edge that accepts them.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            tracker.check_result(o_out_item);
        end
    end

    // Idle length: mostly short, now and then long.
    function automatic int stall_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic int input_gap();
        if (no_idle || $urandom_range(0, 99) < 55) begin
            return 0;
        end
        return stall_length();
    endfunction

    // Receiver side: random back-pressure unless a burst stretch is running.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (!no_idle && stall_left == 0 && $urandom_range(0, 99) < 20) begin
                stall_left = stall_length();
            end
            if (stall_left > 0 && !no_idle) begin
                out_ready <= 1'b0;
                stall_left--;
            end else begin
                stall_left = 0;
                out_ready <= 1'b1;
            end
        end
    end

    function automatic hlst_pkg::t_probe probe_of(logic [15:0] port, logic [31:0] addr,
                                                  logic [31:0] sent, logic [31:0] now_ms);
        hlst_pkg::t_probe p;
        p.quoted_dest_port = port;
        p.source_address   = addr;
        p.sent_time_ms     = sent;
        p.now_time_ms      = now_ms;
        return p;
    endfunction

    // Random reply: mostly hops inside the table with plausible timing.
    function automatic hlst_pkg::t_probe random_probe(logic [hlst_pkg::PORT_W-1:0] base);
        hlst_pkg::t_probe p;
        int               r;
        r = $urandom_range(0, 99);
        if (r < 85) begin
            p.quoted_dest_port = base + hlst_pkg::PORT_W'($urandom_range(0, DEPTH - 1));
        end else if (r < 92) begin
            p.quoted_dest_port = hlst_pkg::PORT_W'($urandom);
        end else if (r < 96) begin
            p.quoted_dest_port = base + hlst_pkg::PORT_W'(DEPTH)
                                 + hlst_pkg::PORT_W'($urandom_range(0, 3));
        end else begin
            p.quoted_dest_port = base - hlst_pkg::PORT_W'($urandom_range(1, 3));
        end
        p.source_address = $urandom;
        p.sent_time_ms   = $urandom;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            p.now_time_ms = p.sent_time_ms + $urandom_range(1, 3000);
        end else if (r < 62) begin
            p.now_time_ms = p.sent_time_ms;
        end else if (r < 70) begin
            p.now_time_ms = p.sent_time_ms + $urandom_range(65535, 200000);
        end else if (r < 80) begin
            p.now_time_ms = p.sent_time_ms - $urandom_range(1, 100000);
        end else if (r < 86) begin
            p.now_time_ms = $urandom;
        end else begin
            p.now_time_ms = p.sent_time_ms + $urandom_range(0, 65535);
        end
        return p;
    endfunction

    // Offers one item after a random gap; entered and left at a falling edge.
    task automatic drive_probe(input hlst_pkg::t_probe p);
        int gap;
        gap = input_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= p;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        tracker.record_probe(p);
        @(negedge i_clk);
    endtask

    // Drops valid and waits until every predicted result has been seen.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (tracker.outstanding() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Register write while nothing is in flight.
    task automatic write_base_port(input logic [hlst_pkg::PORT_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        tracker.set_base_port(value);
        @(negedge i_clk);
    endtask

    task automatic random_phase(input logic [hlst_pkg::PORT_W-1:0] base, input bit burst);
        write_base_port(base);
        no_idle = burst;
        repeat (PHASE_ITEMS) drive_probe(random_probe(base));
        drain_results();
        no_idle = 1'b0;
    endtask

    // Main sequence.
    initial begin
        logic [hlst_pkg::PORT_W-1:0] b;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed replies against the reset base port.
        b = hlst_pkg::BASE_PORT_RESET;
        // Zero round trip leaves min and max unset; then a first real value sets them.
        drive_probe(probe_of(b, 32'h0000_0000, 32'd0, 32'd0));
        drive_probe(probe_of(b, 32'hFFFF_FFFF, 32'd1000, 32'd1005));
        // Reply older than its probe clamps to zero.
        drive_probe(probe_of(b, 32'hAAAA_AAAA, 32'd10, 32'd2));
        drive_probe(probe_of(b, 32'h5555_5555, 32'd0, 32'd3));
        // Last hop with the largest and an over-long round trip.
        drive_probe(probe_of(b + 16'd63, 32'hFFFF_FFFF, 32'd0, 32'd65535));
        drive_probe(probe_of(b + 16'd63, 32'h0000_0001, 32'd5, 32'd65541));
        drive_probe(probe_of(b + 16'd63, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0));
        // Differences at the sign boundary of the timestamp.
        drive_probe(probe_of(b + 16'd1, 32'h1234_5678, 32'd0, 32'h8000_0000));
        drive_probe(probe_of(b + 16'd1, 32'h8765_4321, 32'd0, 32'h7FFF_FFFF));
        drive_probe(probe_of(b + 16'd1, 32'h0F0F_0F0F, 32'hFFFF_0000, 32'hFFFF_FFFF));
        // Ports outside the table, on both sides and at the ends of the field.
        drive_probe(probe_of(b + 16'd64, 32'hDEAD_BEEF, 32'd0, 32'd50));
        drive_probe(probe_of(b - 16'd1, 32'hCAFE_F00D, 32'd0, 32'd50));
        drive_probe(probe_of(16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        drive_probe(probe_of(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        // A middle hop seeing small, tiny and near-limit values.
        drive_probe(probe_of(b + 16'd32, 32'hC0A8_0001, 32'd123456, 32'd124156));
        drive_probe(probe_of(b + 16'd32, 32'hC0A8_0002, 32'd7, 32'd8));
        drive_probe(probe_of(b + 16'd32, 32'hC0A8_0003, 32'd0, 32'd65534));
        drain_results();

        // One hop fed back to back so its count and mean build up.
        no_idle = 1'b1;
        for (int n = 0; n < HOP_BURST; n++) begin
            drive_probe(probe_of(b + 16'd9, $urandom, 32'd1000,
                                 32'd1000 + $urandom_range(0, 70000)));
        end
        drain_results();
        no_idle = 1'b0;

        // Random phases over several base ports, extremes and wrap-around included.
        random_phase(16'h0000, 1'b0);
        random_phase(16'hFFFF, 1'b0);
        random_phase(16'hFFFF - 16'd20, 1'b0);
        random_phase(hlst_pkg::PORT_W'($urandom), 1'b1);
        random_phase(hlst_pkg::BASE_PORT_RESET, 1'b0);
        random_phase(hlst_pkg::PORT_W'($urandom), 1'b0);

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (tracker.mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
